### hdl/percent_encode_then_base64_encoder_assert.svh
// assertion macros shared by the encoder modules
`ifndef PERCENT_ENCODE_THEN_BASE64_ENCODER_ASSERT_SVH
`define PERCENT_ENCODE_THEN_BASE64_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PE64_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PE64_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);
`else
`define PE64_ASSERT(label, prop, msg)
`define PE64_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

### hdl/pe64_pkg.sv
// types, constants and character helpers for the percent-encode then base64 encoder
package pe64_pkg;

    localparam int QDEPTH_DEF = 4;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [6:0] CHAR_PAD     = 7'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] b64_char;
        logic       final_char;
    } out_item_t;

    // one classified input byte: either one literal byte or three escape bytes
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       esc;
        logic       fin;
    } job_t;

    function automatic logic is_safe(input logic [7:0] c);
        logic r;
        begin
            r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) ||
                c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E ||
                c == 8'h21 || c == 8'h2A || c == 8'h27 || c == 8'h28 || c == 8'h29;
            return r;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        begin
            if (n < 4'd10)
                r = 8'h30 + {4'h0, n};
            else
                r = 8'h37 + {4'h0, n};
            return r;
        end
    endfunction

    function automatic logic [6:0] b64_symbol(input logic [5:0] s);
        logic [6:0] r;
        begin
            if (s < 6'd26)
                r = 7'h41 + {1'b0, s};
            else if (s < 6'd52)
                r = 7'h47 + {1'b0, s};
            else if (s < 6'd62)
                r = {1'b0, s} - 7'h04;
            else if (s == 6'd62)
                r = 7'h2B;
            else
                r = 7'h2F;
            return r;
        end
    endfunction

endpackage

### hdl/pe64_front.sv
// front end: classifies each input byte into a literal or an escape job
module pe64_front (
    input  logic             push,
    input  logic             full,
    input  pe64_pkg::in_item_t item,
    output logic             wr_en,
    output pe64_pkg::job_t   job
);
    import pe64_pkg::*;

    logic safe;

    always_comb
    begin
        safe  = is_safe(item.data_byte);
        wr_en = push && !full;
        job.fin = item.final_byte;
        job.esc = !safe;
        if (safe)
        begin
            job.b0 = item.data_byte;
            job.b1 = item.data_byte;
            job.b2 = item.data_byte;
        end
        else
        begin
            job.b0 = CHAR_PERCENT;
            job.b1 = hex_digit(item.data_byte[7:4]);
            job.b2 = hex_digit(item.data_byte[3:0]);
        end
    end

endmodule

### hdl/pe64_fifo.sv
// small register queue between the front end and the back end
`include "percent_encode_then_base64_encoder_assert.svh"
module pe64_fifo #(
    parameter int DEPTH = pe64_pkg::QDEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pe64_pkg::job_t wr_data,
    input  logic           rd_en,
    output pe64_pkg::job_t rd_data,
    output logic           full,
    output logic           empty
);
    import pe64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = cnt_reg == CW'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CW'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `PE64_ASSERT(a_cnt_range, cnt_reg <= CW'(DEPTH), "queue count beyond depth")
    `PE64_ASSERT(a_no_rd_empty, rd_en |-> cnt_reg != '0, "read from empty queue")
    `PE64_ASSERT_NEXT(a_wr_fills, do_wr, cnt_reg != '0, "queue empty after write")

endmodule

### hdl/pe64_back.sv
// back end: packs intermediate bytes into groups and emits one base64 character per beat
`include "percent_encode_then_base64_encoder_assert.svh"
module pe64_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pe64_pkg::job_t    q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output pe64_pkg::out_item_t result
);
    import pe64_pkg::*;

    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [2:0]  left_reg, left_next;
    logic [7:0]  p0_reg, p1_reg;
    logic [23:0] word_reg;
    logic [1:0]  vld_reg;
    logic        gfin_reg;

    logic [7:0]  cur_byte;
    logic        last_sub, load_need, grp_free, adv, pop_out;
    logic [23:0] word_new;
    logic [1:0]  vld_new;
    logic [1:0]  idx;
    logic [5:0]  sextet;

    always_comb
    begin
        case (sub_reg)
            2'd0:    cur_byte = q_data.b0;
            2'd1:    cur_byte = q_data.b1;
            default: cur_byte = q_data.b2;
        endcase
        last_sub  = !q_data.esc || sub_reg == 2'd2;
        // a group closes on the third byte, or on the last byte of the string
        load_need = cnt_reg == 2'd2 || (q_data.fin && last_sub);
        grp_free  = left_reg == 3'd0 || (left_reg == 3'd1 && pop);
        adv       = !q_empty && (!load_need || grp_free);
        q_pop     = adv && last_sub;
        pop_out   = pop && left_reg != 3'd0;

        case (cnt_reg)
            2'd2:
            begin
                word_new = {p0_reg, p1_reg, cur_byte};
                vld_new  = 2'd3;
            end
            2'd1:
            begin
                word_new = {p0_reg, cur_byte, 8'h00};
                vld_new  = 2'd2;
            end
            default:
            begin
                word_new = {cur_byte, 16'h0000};
                vld_new  = 2'd1;
            end
        endcase

        sub_next  = sub_reg;
        cnt_next  = cnt_reg;
        left_next = pop_out ? left_reg - 3'd1 : left_reg;
        if (adv)
        begin
            sub_next = last_sub ? 2'd0 : sub_reg + 2'd1;
            if (load_need)
            begin
                cnt_next  = 2'd0;
                left_next = 3'd4;
            end
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= 2'd0;
            cnt_reg  <= 2'd0;
            left_reg <= 3'd0;
        end
        else
        begin
            sub_reg  <= sub_next;
            cnt_reg  <= cnt_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && !load_need)
        begin
            if (cnt_reg == 2'd0)
                p0_reg <= cur_byte;
            else
                p1_reg <= cur_byte;
        end
        if (adv && load_need)
        begin
            word_reg <= word_new;
            vld_reg  <= vld_new;
            gfin_reg <= q_data.fin && last_sub;
        end
    end

    // character position within the group being shown
    always_comb
    begin
        idx = 2'(3'd4 - left_reg);
        case (idx)
            2'd0:    sextet = word_reg[23:18];
            2'd1:    sextet = word_reg[17:12];
            2'd2:    sextet = word_reg[11:6];
            default: sextet = word_reg[5:0];
        endcase
        empty = left_reg == 3'd0;
        if ((idx == 2'd2 && vld_reg < 2'd2) || (idx == 2'd3 && vld_reg < 2'd3))
            result.b64_char = CHAR_PAD;
        else
            result.b64_char = b64_symbol(sextet);
        result.final_char = gfin_reg && left_reg == 3'd1;
    end

    `PE64_ASSERT(a_cnt_range, cnt_reg != 2'd3, "pending count out of range")
    `PE64_ASSERT(a_left_range, left_reg <= 3'd4, "group character count out of range")
    `PE64_ASSERT(a_esc_held, sub_reg != 2'd0 |-> !q_empty && q_data.esc && sub_reg != 2'd3,
                 "escape sequence lost its queue entry")

endmodule

### hdl/percent_encode_then_base64_encoder.sv
// top level: percent-encode then base64 encoder, queue in and queue out
// path: an accepted byte is registered in the queue, then its group is registered in the character buffer
// throughput: one character per cycle while pop is held and empty is low; a literal byte is one
// intermediate byte, an escaped byte three, and a group's four characters wait on the result port for pop
// reset: asynchronous, clears the queue, pending byte count and character buffer
module percent_encode_then_base64_encoder #(
    parameter int QDEPTH = pe64_pkg::QDEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  pe64_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output pe64_pkg::out_item_t result
);
    import pe64_pkg::*;

    logic wr_en, q_pop, q_empty;
    job_t job_in, job_out;

    pe64_front u_front (
        .push  (push),
        .full  (full),
        .item  (item),
        .wr_en (wr_en),
        .job   (job_in)
    );

    pe64_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (job_in),
        .rd_en   (q_pop),
        .rd_data (job_out),
        .full    (full),
        .empty   (q_empty)
    );

    pe64_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (job_out),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
